### rtl/fcca_pkg.sv
// ----------------------------------------------------------------------------
// fcca_pkg
// Shared widths, codes and constants of the FAT12 cluster chain allocator.
// ----------------------------------------------------------------------------
package fcca_pkg;

  localparam int unsigned CW           = 12;      // cluster entry and index width
  localparam int unsigned DEF_CLUSTERS = 2048;

  localparam logic [CW-1:0] MEDIA_ENTRY  = 12'hFF0;
  localparam logic [CW-1:0] END_OF_CHAIN = 12'hFFF;
  localparam logic [CW-1:0] FIRST_DATA   = 12'd2;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD      = 2'd2
  } status_t;

endpackage

### rtl/fcca_ram.sv
// ----------------------------------------------------------------------------
// fcca_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fcca_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/fat12_cluster_chain_allocator.sv
// ----------------------------------------------------------------------------
// fat12_cluster_chain_allocator
// FAT12 table of cluster entries with chain allocation and entry reads.
//
//   Channel | Dir | Transfer contents
//   in_     | in  | tuser: opcode; tdata: request_count, entry_index
//   out_    | out | tuser: status; tdata: chain_head, read_value, free_total
//
// A read of a stored entry goes through S_READ (one table RAM access); reserved,
// unallocated and out-of-range reads and failed allocates are answered from S_IDLE.
// An allocate makes one RAM write per cluster in S_ALLOC on the single write port.
// Clusters are never released, so allocated clusters always form a run from
// cluster two up to a fill mark; entries at and above the mark read as zero,
// hence reset needs no clearing pass and the block is ready straight after it.
// A new transfer is taken while the previous result is being transferred out.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_allocator
  import fcca_pkg::*;
#(
  parameter int unsigned NUM_CLUSTERS = DEF_CLUSTERS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [11:0] request_count, [23:12] entry_index
  input  logic [0:0]  in_tuser,   // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [11:0] chain_head, [23:12] read_value,
                                  // [35:24] free_total, [39:36] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int unsigned AW = $clog2(NUM_CLUSTERS);
  localparam logic [CW:0]   NUM_EXT    = (CW+1)'(NUM_CLUSTERS);
  localparam logic [CW-1:0] FREE_RESET = CW'(NUM_CLUSTERS - 2);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_READ
  } state_t;

  state_t        state_r, state_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] hwm_r, hwm_nxt;
  logic [CW-1:0] free_r, free_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] last_r, last_nxt;
  logic [CW-1:0] out_first_r, out_first_nxt;
  logic [CW-1:0] out_value_r, out_value_nxt;
  logic [CW-1:0] out_free_r, out_free_nxt;
  status_t       out_status_r, out_status_nxt;

  logic          in_xfer;
  op_t           op;
  logic [CW-1:0] req_count;
  logic [CW-1:0] idx;
  logic          ram_we;
  logic [CW-1:0] ram_wdata;
  logic          ram_re;
  logic [CW-1:0] ram_rdata;
  logic          alloc_last;

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_xfer    = in_tvalid && in_tready;
  assign op         = op_t'(in_tuser[0]);
  assign req_count  = in_tdata[11:0];
  assign idx        = in_tdata[23:12];
  assign alloc_last = (ptr_r == last_r);

  assign ram_we    = (state_r == S_ALLOC);
  assign ram_wdata = alloc_last ? END_OF_CHAIN : ptr_r + 1'b1;
  assign ram_re    = in_xfer && (op == OP_READ);

  fcca_ram #(
    .WIDTH (CW),
    .DEPTH (NUM_CLUSTERS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r[AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    hwm_nxt        = hwm_r;
    free_nxt       = free_r;
    ptr_nxt        = ptr_r;
    last_nxt       = last_r;
    out_first_nxt  = out_first_r;
    out_value_nxt  = out_value_r;
    out_free_nxt   = out_free_r;
    out_status_nxt = out_status_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          out_first_nxt  = '0;
          out_value_nxt  = '0;
          out_free_nxt   = free_r;
          out_status_nxt = ST_OK;
          if (op == OP_ALLOC) begin
            priority if (req_count == '0) begin
              out_status_nxt = ST_BAD;
              out_valid_nxt  = 1'b1;
            end else if (req_count > free_r) begin
              out_status_nxt = ST_NO_SPACE;
              out_valid_nxt  = 1'b1;
            end else begin
              ptr_nxt   = hwm_r;
              last_nxt  = hwm_r + req_count - 1'b1;
              state_nxt = S_ALLOC;
            end
          end else begin
            priority if ({1'b0, idx} >= NUM_EXT) begin
              out_status_nxt = ST_BAD;
              out_valid_nxt  = 1'b1;
            end else if (idx == '0) begin
              out_value_nxt = MEDIA_ENTRY;
              out_valid_nxt = 1'b1;
            end else if (idx < FIRST_DATA) begin
              out_value_nxt = END_OF_CHAIN;
              out_valid_nxt = 1'b1;
            end else if (idx < hwm_r) begin
              state_nxt = S_READ;
            end else begin
              // At and above the fill mark every cluster is still free.
              out_valid_nxt = 1'b1;
            end
          end
        end
      end
      S_ALLOC: begin
        ptr_nxt = ptr_r + 1'b1;
        if (alloc_last) begin
          hwm_nxt        = ptr_r + 1'b1;
          free_nxt       = free_r - (ptr_r + 1'b1 - hwm_r);
          out_first_nxt  = hwm_r;
          out_free_nxt   = free_r - (ptr_r + 1'b1 - hwm_r);
          out_status_nxt = ST_OK;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_READ: begin
        out_value_nxt = ram_rdata;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hwm_r       <= FIRST_DATA;
      free_r      <= FREE_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hwm_r       <= hwm_nxt;
      free_r      <= free_nxt;
    end
    ptr_r        <= ptr_nxt;
    last_r       <= last_nxt;
    out_first_r  <= out_first_nxt;
    out_value_r  <= out_value_nxt;
    out_free_r   <= out_free_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {4'b0000, out_free_r, out_value_r, out_first_r};

  // The result register must be free whenever a new transfer is taken.
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> (!out_valid_r || out_tready))
    else $error("input taken while result register stays occupied");

  // The free count and the fill mark together always add up to the table size.
  a_count_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, free_r} + {1'b0, hwm_r}) == NUM_EXT)
    else $error("free count disagrees with fill mark");

  // The write pointer never passes the end of the chain being built.
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC) |-> (ptr_r <= last_r && last_r < NUM_EXT[CW-1:0]))
    else $error("allocation pointer beyond chain end");

  // A read of stored data produces its result in the cycle after the S_READ state.
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (out_valid_r && state_r == S_IDLE))
    else $error("read result not delivered");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT12 cluster chain allocator testbench
// Directed table, then random allocate and read traffic. A shadow copy of the
// cluster table predicts every result that the table does not give, and results are checked in order.
// Both stream sides idle at random, and once the output is held off long
// enough to back the block up onto its input.
// ----------------------------------------------------------------------------
module testbench
  import fcca_pkg::*;
;

  localparam int unsigned NUM         = DEF_CLUSTERS;
  localparam int          RANDOM_ITEMS = 270;
  localparam int          LONG_HOLD    = 300;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [CW-1:0] chain_head;
    status_t       status;
    logic [CW-1:0] read_value;
    logic [CW-1:0] free_total;
  } fat_result_t;

  typedef struct {
    op_t           op;
    logic [CW-1:0] count;
    logic [CW-1:0] index;
    bit            typed;
    fat_result_t   res;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [11:0] request_count, [23:12] entry_index
  logic [0:0]  in_tuser;   // [0] opcode
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [11:0] chain_head, [23:12] read_value,
                           // [35:24] free_total, [39:36] zero
  logic [1:0]  out_tuser;  // [1:0] status

  fat12_cluster_chain_allocator #(.NUM_CLUSTERS(NUM)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Shadow of the allocation table and the free cluster register.
  logic [CW-1:0] fat_shadow [NUM];
  int            free_left;

  fat_result_t   pending_results [$];
  dir_row_t      dir_rows [$];

  int cycle_count  = 0;
  int errors       = 0;
  int results_seen = 0;
  int n_chains     = 0;
  int n_no_space   = 0;
  int n_bad        = 0;
  int n_reads      = 0;
  bit held_off     = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
    errors++;
    if (errors <= 20)
      $display("Mismatch at cycle %0d: %s got 0x%0h, expected 0x%0h", cycle_count, what,
               got, want);
  endtask

  // Applies one request to the shadow table and returns what the block should send.
  function automatic fat_result_t fat_apply(op_t op, logic [CW-1:0] count,
                                            logic [CW-1:0] index);
    fat_result_t res;
    int          left;
    int          prev;
    res = '{chain_head: '0, status: ST_OK, read_value: '0, free_total: '0};
    if (op == OP_ALLOC) begin
      if (count == 0) begin
        res.status = ST_BAD;
      end else if (count > free_left) begin
        res.status = ST_NO_SPACE;
      end else begin
        left = count;
        prev = -1;
        for (int i = FIRST_DATA; i < NUM && left > 0; i++) begin
          if (fat_shadow[i] == '0) begin
            if (prev >= 0)
              fat_shadow[prev] = CW'(i);
            else
              res.chain_head = CW'(i);
            fat_shadow[i] = END_OF_CHAIN;
            prev = i;
            left--;
          end
        end
        free_left = free_left - count;
      end
    end else if (index >= NUM) begin
      res.status = ST_BAD;
    end else begin
      res.read_value = fat_shadow[index];
    end
    res.free_total = CW'(free_left);
    return res;
  endfunction

  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 40);
  endfunction

  task automatic add_row(op_t op, logic [CW-1:0] count, logic [CW-1:0] index, bit typed,
                         status_t st, logic [CW-1:0] first, logic [CW-1:0] value,
                         logic [CW-1:0] free);
    dir_row_t row;
    row.op    = op;
    row.count = count;
    row.index = index;
    row.typed = typed;
    row.res   = '{chain_head: first, status: st, read_value: value, free_total: free};
    dir_rows.push_back(row);
  endtask

  // Offers one request, waits for its transfer and records the expected result.
  task automatic offer_item(op_t op, logic [CW-1:0] count, logic [CW-1:0] index, bit burst,
                            bit typed, fat_result_t typed_res);
    int          gap;
    fat_result_t res;
    gap = pick_gap(burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {index, count};
    do @(posedge clk); while (!in_tready);
    res = fat_apply(op, count, index);
    pending_results.push_back(typed ? typed_res : res);
    if (op == OP_READ)
      n_reads++;
    else if (res.status == ST_OK)
      n_chains++;
    else if (res.status == ST_NO_SPACE)
      n_no_space++;
    else
      n_bad++;
  endtask

  initial begin : stimulus
    int            k;
    int            r;
    int            s;
    int            fill;
    op_t           op;
    logic [CW-1:0] count;
    logic [CW-1:0] index;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    for (int i = 0; i < NUM; i++)
      fat_shadow[i] = '0;
    fat_shadow[0] = MEDIA_ENTRY;
    fat_shadow[1] = END_OF_CHAIN;
    free_left     = NUM - 2;

    // Reserved entries, range limits and the refused requests first, then allocations and reads.
    add_row(OP_READ,  12'd0,    12'd0,    1, ST_OK,       12'd0, 12'hFF0, 12'd2046);
    add_row(OP_READ,  12'd0,    12'd1,    1, ST_OK,       12'd0, 12'hFFF, 12'd2046);
    add_row(OP_READ,  12'd0,    12'd2,    1, ST_OK,       12'd0, 12'h000, 12'd2046);
    add_row(OP_READ,  12'd4095, 12'd2047, 1, ST_OK,       12'd0, 12'h000, 12'd2046);
    add_row(OP_READ,  12'd0,    12'd2048, 1, ST_BAD,      12'd0, 12'h000, 12'd2046);
    add_row(OP_READ,  12'd0,    12'd4095, 1, ST_BAD,      12'd0, 12'h000, 12'd2046);
    add_row(OP_ALLOC, 12'd0,    12'd0,    1, ST_BAD,      12'd0, 12'h000, 12'd2046);
    add_row(OP_ALLOC, 12'd4095, 12'd0,    1, ST_NO_SPACE, 12'd0, 12'h000, 12'd2046);
    add_row(OP_ALLOC, 12'd2047, 12'd0,    1, ST_NO_SPACE, 12'd0, 12'h000, 12'd2046);
    add_row(OP_ALLOC, 12'd1,    12'd0,    1, ST_OK,       12'd2, 12'h000, 12'd2045);
    add_row(OP_READ,  12'd0,    12'd2,    1, ST_OK,       12'd0, 12'hFFF, 12'd2045);
    add_row(OP_ALLOC, 12'd3,    12'd4095, 1, ST_OK,       12'd3, 12'h000, 12'd2042);
    add_row(OP_READ,  12'd0,    12'd3,    0, ST_OK,       12'd0, 12'h000, 12'd0);
    add_row(OP_READ,  12'd0,    12'd4,    0, ST_OK,       12'd0, 12'h000, 12'd0);
    add_row(OP_READ,  12'd0,    12'd5,    0, ST_OK,       12'd0, 12'h000, 12'd0);
    add_row(OP_ALLOC, 12'd2043, 12'd0,    1, ST_NO_SPACE, 12'd0, 12'h000, 12'd2042);
    add_row(OP_ALLOC, 12'd700,  12'd0,    0, ST_OK,       12'd0, 12'h000, 12'd0);
    add_row(OP_READ,  12'd0,    12'd6,    0, ST_OK,       12'd0, 12'h000, 12'd0);
    add_row(OP_READ,  12'd0,    12'd704,  0, ST_OK,       12'd0, 12'h000, 12'd0);
    add_row(OP_READ,  12'd0,    12'd705,  0, ST_OK,       12'd0, 12'h000, 12'd0);
    add_row(OP_ALLOC, 12'd1,    12'd0,    0, ST_OK,       12'd0, 12'h000, 12'd0);
    add_row(OP_READ,  12'd0,    12'd706,  0, ST_OK,       12'd0, 12'h000, 12'd0);
    add_row(OP_READ,  12'd0,    12'd0,    0, ST_OK,       12'd0, 12'h000, 12'd0);

    @(posedge clk iff rst_n);
    k = 0;
    foreach (dir_rows[i]) begin
      offer_item(dir_rows[i].op, dir_rows[i].count, dir_rows[i].index, (k / 8) % 2 == 0,
                 dir_rows[i].typed, dir_rows[i].res);
      k++;
    end

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      r    = $urandom_range(0, 99);
      s    = $urandom_range(0, 99);
      fill = NUM - free_left;
      if (fill > NUM - 1)
        fill = NUM - 1;
      if (r < 65) begin
        op    = OP_ALLOC;
        index = CW'($urandom_range(0, 4095));
        if (s < 60)
          count = CW'($urandom_range(1, 12));
        else if (s < 75)
          count = CW'($urandom_range(13, 120));
        else if (s < 82)
          count = '0;
        else if (s < 88)
          count = CW'($urandom_range(0, 4095));
        else if (k >= RANDOM_ITEMS / 2)
          // Exact fit or one too many, so the table is driven to full.
          count = CW'(free_left + $urandom_range(0, 1));
        else
          count = CW'($urandom_range(1, 6));
      end else begin
        op    = OP_READ;
        count = CW'($urandom_range(0, 4095));
        if (s < 60)
          index = CW'($urandom_range(0, fill));
        else if (s < 85)
          index = CW'($urandom_range(0, NUM - 1));
        else
          index = CW'($urandom_range(0, 4095));
      end
      offer_item(op, count, index, (k / 40) % 3 == 0, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d chains allocated, %0d refused for space, %0d bad",
             n_chains + n_no_space + n_bad + n_reads, n_chains, n_no_space, n_bad);
    $display("and %0d entry reads; %0d clusters left free, one output hold of %0d cycles.",
             n_reads, free_left, LONG_HOLD);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Output side: random back-pressure, with one long hold-off once traffic is flowing.
  initial begin : result_sink
    int gap;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!held_off && results_seen >= 120) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        gap = pick_gap((results_seen / 40) % 3 == 1);
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    fat_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, chain_head", out_tdata[11:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[11:0] !== want.chain_head)
          report_mismatch("chain_head", out_tdata[11:0], want.chain_head);
        if (out_tuser !== want.status)
          report_mismatch("status", CW'(out_tuser), CW'(want.status));
        if (out_tdata[23:12] !== want.read_value)
          report_mismatch("read_value", out_tdata[23:12], want.read_value);
        if (out_tdata[35:24] !== want.free_total)
          report_mismatch("free_total", out_tdata[35:24], want.free_total);
      end
    end
  end

endmodule

### files.f
rtl/fcca_pkg.sv
rtl/fcca_ram.sv
rtl/fat12_cluster_chain_allocator.sv
tb/testbench.sv
